// ===== hw/rtl/plo_pkg.sv =====
// Package for the positional line order list: sizes, codes and controller states.
package plo_pkg;

   localparam int Capacity  = 4096;
   localparam int AddrWidth = 12;
   localparam int IdWidth   = 13;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_ERASE  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_RD,
      ST_INS_WR,
      ST_ERS_FETCH,
      ST_ERS_RD,
      ST_ERS_WR,
      ST_RD_FETCH
   } state_type;

endpackage

// ===== hw/rtl/positional_line_order_list_top.sv =====
// Top level of the positional line order list: controller and order memory.
//
// The list is kept compacted in one synchronous memory of 4096 identifiers
// with a registered read. A command word is taken when start is high and
// busy is low; its result word appears on the rsp_ ports for one cycle,
// marked by rsp_valid, and the receiver cannot stall it. Append and every
// out-of-range or full command are settled in the check state, whose result
// is registered onto the rsp_ ports; read passes the check state and a fetch
// state before its result is registered. Insert and erase move every entry
// behind the position by one place, each move being a memory read followed
// by a write through the single memory port pair, so they take longer the
// more entries lie behind the position. Busy falls in the cycle that carries
// the result word, so the next command can be taken at the edge that ends
// that cycle.
module positional_line_order_list_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_position,
   output logic        rsp_valid,
   output logic [12:0] rsp_line_id,
   output logic [1:0]  rsp_status
);

   localparam logic [12:0] CapVal = 13'(plo_pkg::Capacity);

   logic [12:0] order_mem [plo_pkg::Capacity];
   logic [12:0] rd_data_ff;
   logic        mem_we;
   logic [11:0] mem_wa;
   logic [12:0] mem_wd;
   logic [11:0] mem_ra;

   plo_pkg::state_type state_ff, state_in;
   plo_pkg::kind_type  kind_ff, kind_in;
   logic [12:0] pos_ff, pos_in;
   logic [12:0] len_ff, len_in;
   logic [12:0] nid_ff, nid_in;
   logic [12:0] rem_ff, rem_in;
   logic [12:0] idx_ff, idx_in;
   logic [12:0] id_ff, id_in;
   logic        valid_ff, valid_in;
   logic [12:0] out_id_ff, out_id_in;
   logic [1:0]  out_st_ff, out_st_in;

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         order_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= order_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plo_pkg::ST_IDLE;
         len_ff   <= '0;
         nid_ff   <= '0;
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         nid_ff   <= nid_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      out_id_ff <= out_id_in;
      out_st_ff <= out_st_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      nid_in    = nid_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      valid_in  = 1'b0;
      out_id_in = out_id_ff;
      out_st_in = out_st_ff;
      mem_we    = 1'b0;
      mem_wa    = idx_ff[11:0];
      mem_wd    = rd_data_ff;
      mem_ra    = pos_ff[11:0];

      unique case (state_ff)
         plo_pkg::ST_IDLE: begin
            if (start) begin
               kind_in  = plo_pkg::kind_type'(req_kind);
               pos_in   = {1'b0, req_position};
               state_in = plo_pkg::ST_CHECK;
            end
         end
         plo_pkg::ST_CHECK: begin
            state_in  = plo_pkg::ST_IDLE;
            valid_in  = 1'b1;
            out_id_in = '0;
            out_st_in = plo_pkg::STATUS_DONE;
            unique case (kind_ff)
               plo_pkg::KIND_APPEND: begin
                  if (len_ff == CapVal || nid_ff == CapVal) begin
                     out_st_in = plo_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wa    = len_ff[11:0];
                     mem_wd    = nid_ff + 13'd1;
                     nid_in    = nid_ff + 13'd1;
                     len_in    = len_ff + 13'd1;
                     out_id_in = nid_ff + 13'd1;
                  end
               end
               plo_pkg::KIND_INSERT: begin
                  if (pos_ff > len_ff) begin
                     out_st_in = plo_pkg::STATUS_RANGE;
                  end else if (len_ff == CapVal) begin
                     out_st_in = plo_pkg::STATUS_FULL;
                  end else begin
                     // Open the gap from the tail down to the position.
                     valid_in = 1'b0;
                     idx_in   = len_ff;
                     state_in = plo_pkg::ST_INS_RD;
                  end
               end
               plo_pkg::KIND_ERASE: begin
                  if (pos_ff >= len_ff) begin
                     out_st_in = plo_pkg::STATUS_RANGE;
                  end else begin
                     valid_in = 1'b0;
                     state_in = plo_pkg::ST_ERS_FETCH;
                  end
               end
               plo_pkg::KIND_READ: begin
                  if (pos_ff >= len_ff) begin
                     out_st_in = plo_pkg::STATUS_RANGE;
                  end else begin
                     valid_in = 1'b0;
                     state_in = plo_pkg::ST_RD_FETCH;
                  end
               end
               default: ;
            endcase
         end
         plo_pkg::ST_INS_RD: begin
            if (idx_ff == pos_ff) begin
               mem_we    = 1'b1;
               mem_wd    = rem_ff;
               len_in    = len_ff + 13'd1;
               valid_in  = 1'b1;
               out_id_in = rem_ff;
               out_st_in = plo_pkg::STATUS_DONE;
               state_in  = plo_pkg::ST_IDLE;
            end else begin
               mem_ra   = 12'(idx_ff - 13'd1);
               state_in = plo_pkg::ST_INS_WR;
            end
         end
         plo_pkg::ST_INS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff - 13'd1;
            state_in = plo_pkg::ST_INS_RD;
         end
         plo_pkg::ST_ERS_FETCH: begin
            id_in    = rd_data_ff;
            idx_in   = pos_ff;
            state_in = plo_pkg::ST_ERS_RD;
         end
         plo_pkg::ST_ERS_RD: begin
            if (idx_ff + 13'd1 >= len_ff) begin
               len_in    = len_ff - 13'd1;
               valid_in  = 1'b1;
               out_id_in = id_ff;
               out_st_in = plo_pkg::STATUS_DONE;
               state_in  = plo_pkg::ST_IDLE;
            end else begin
               mem_ra   = 12'(idx_ff + 13'd1);
               state_in = plo_pkg::ST_ERS_WR;
            end
         end
         plo_pkg::ST_ERS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + 13'd1;
            state_in = plo_pkg::ST_ERS_RD;
         end
         plo_pkg::ST_RD_FETCH: begin
            rem_in    = rd_data_ff;
            valid_in  = 1'b1;
            out_id_in = rd_data_ff;
            out_st_in = plo_pkg::STATUS_DONE;
            state_in  = plo_pkg::ST_IDLE;
         end
         default: state_in = plo_pkg::ST_IDLE;
      endcase
   end

   assign busy        = (state_ff != plo_pkg::ST_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_line_id = out_id_ff;
   assign rsp_status  = out_st_ff;

endmodule
